@@ hdl/assert_macros.svh @@
// Assertion macros shared by the multi-tap text entry RTL.
// Define NO_ASSERTIONS to compile them out; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_RST(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_RST(lbl, clk, rst, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

@@ hdl/mte_pkg.sv @@
// Shared constants, command/status types and the letter table for the text entry core.
// No dependencies.
package mte_pkg;

  localparam int LINE_LEN = 32;
  localparam int SHOW_LEN = (LINE_LEN < 32) ? LINE_LEN : 32;
  localparam int IDX_W    = $clog2(LINE_LEN);
  localparam int CNT_W    = $clog2(LINE_LEN + 1);
  localparam int SUM_W    = CNT_W + 1;

  localparam logic [3:0] NO_KEY     = 4'd15;
  localparam logic [6:0] CHAR_SPACE = 7'h20;
  localparam logic [6:0] CHAR_ONE   = 7'h31;

  typedef struct packed {
    logic       load;
    logic       lookup;
    logic       apply;
    logic       emit;
    logic [4:0] emit_idx;
    logic       emit_last;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic out_empty;
  } sts_t;

  // {third, second, first} letter of a key
  function automatic logic [20:0] letter_triple(input logic [3:0] key);
    logic [20:0] t;
    case (key)
      4'd0:    t = {7'h5A, 7'h51, 7'h2E};
      4'd1:    t = {7'h43, 7'h42, 7'h41};
      4'd2:    t = {7'h46, 7'h45, 7'h44};
      4'd3:    t = {7'h49, 7'h48, 7'h47};
      4'd4:    t = {7'h4C, 7'h4B, 7'h4A};
      4'd5:    t = {7'h4F, 7'h4E, 7'h4D};
      4'd6:    t = {7'h53, 7'h52, 7'h50};
      4'd7:    t = {7'h56, 7'h55, 7'h54};
      4'd8:    t = {7'h59, 7'h58, 7'h57};
      default: t = '0;
    endcase
    return t;
  endfunction

  // position base+off in the circular line buffer
  function automatic logic [IDX_W-1:0] wrap_pos(input logic [IDX_W-1:0] base,
                                                input logic [CNT_W-1:0] off);
    logic [SUM_W-1:0] s;
    s = SUM_W'(base) + SUM_W'(off);
    if (s >= SUM_W'(LINE_LEN)) begin
      s = s - SUM_W'(LINE_LEN);
    end
    return s[IDX_W-1:0];
  endfunction

endpackage

@@ hdl/multitap_text_entry_core.sv @@
// Top level of the multi-tap keypad text entry core.
// Depends on mte_pkg, mte_ctrl, mte_datapath and assert_macros.svh.

// Each input beat is one nine-key snapshot; each snapshot updates the text line and
// then streams the whole line out as 32 beats, one character per beat, the last one
// marked by m_tlast. An item is latched, the last character is looked up and the
// update applied, then the line is output one character per cycle while m_tready
// allows, through the single read port of the line memory. A new snapshot is
// taken as soon as the final beat of the previous item is loaded into the output
// register, but its update waits until that beat has been taken.
`include "assert_macros.svh"
module multitap_text_entry_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // keys[8:0], zero padded
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // char_index[4:0], char_code[11:5], text_length[17:12],
                                 // number_mode[18], count_thousands[22:19],
                                 // count_hundreds[26:23], count_tens[30:27],
                                 // count_ones[34:31], zero padded
  output logic        m_tlast    // last_char
);

  mte_pkg::cmd_t cmd;
  mte_pkg::sts_t sts;

  mte_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  mte_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .cmd      (cmd),
    .sts      (sts),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  `ASSERT_RST(a_one_item, clk, rst, (s_tvalid && s_tready) |=> !s_tready, "second item taken while busy")
  `ASSERT_ALWAYS(a_apply_drained, clk, cmd.apply |-> !m_tvalid, "state updated with a beat pending")
  `ASSERT_RST(a_last_index, clk, rst, (m_tvalid && m_tlast) |-> (m_tdata[4:0] == 5'(mte_pkg::SHOW_LEN - 1)), "tlast on wrong index")

endmodule

@@ hdl/mte_datapath.sv @@
// Datapath: key latch, circular line memory, mode/count registers and output beat register.
// Depends on mte_pkg; driven by mte_ctrl commands.
module mte_datapath (
  input  logic              clk,
  input  logic              rst,
  input  logic [15:0]       s_tdata,   // [8:0] keys
  input  mte_pkg::cmd_t     cmd,
  output mte_pkg::sts_t     sts,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [39:0]       m_tdata,   // char_index, char_code, text_length, number_mode,
                                       // count_thousands, count_hundreds, count_tens, count_ones
  output logic              m_tlast    // last_char
);

  logic [6:0]                  mem [mte_pkg::LINE_LEN];
  logic [8:0]                  key_snap;
  logic [mte_pkg::IDX_W-1:0]   head, head_next;
  logic [mte_pkg::CNT_W-1:0]   count, count_next, last_off;
  logic [3:0]                  last_key, last_key_next;
  logic                        mode, mode_next;
  logic [15:0]                 press_bcd;
  logic [1:0]                  add_amt;
  logic [6:0]                  rdata;
  logic [4:0]                  out_idx;
  logic                        out_last, out_blank, out_valid;

  logic [3:0]                  k;
  logic [20:0]                 triple;
  logic [6:0]                  t0, t1, t2;
  logic                        app, rep, we, rd_en;
  logic [6:0]                  app_char, rep_char, wdata;
  logic [mte_pkg::IDX_W-1:0]   app_addr, last_addr, emit_addr, waddr, raddr;

  function automatic logic [15:0] bcd_add(input logic [15:0] v, input logic [1:0] amt);
    logic [4:0]  s;
    logic [1:0]  c;
    logic [15:0] r;
    c = amt;
    r = v;
    for (int d = 0; d < 4; d++) begin
      s = 5'(r[d*4 +: 4]) + 5'(c);
      if (s >= 5'd10) begin
        s = s - 5'd10;
        c = 2'd1;
      end else begin
        c = 2'd0;
      end
      r[d*4 +: 4] = s[3:0];
    end
    return r;
  endfunction

  assign sts.out_free  = !out_valid || m_tready;
  assign sts.out_empty = !out_valid;

  always_comb begin
    k = 4'd0;
    for (int b = 8; b >= 0; b--) begin
      if (key_snap[b]) begin
        k = 4'(b);
      end
    end
  end

  assign triple = mte_pkg::letter_triple(k);
  assign t0 = triple[6:0];
  assign t1 = triple[13:7];
  assign t2 = triple[20:14];

  assign last_off  = (count == '0) ? '0 : count - 1'b1;
  assign app_addr  = mte_pkg::wrap_pos(head, count);
  assign last_addr = mte_pkg::wrap_pos(head, last_off);
  assign emit_addr = mte_pkg::wrap_pos(head, mte_pkg::CNT_W'(cmd.emit_idx));

  always_comb begin
    if (rdata == t0) begin
      rep_char = t1;
    end else if (rdata == t1) begin
      rep_char = t2;
    end else if (rdata == t2) begin
      rep_char = t0;
    end else begin
      rep_char = t1;
    end
  end

  always_comb begin
    count_next    = count;
    head_next     = head;
    last_key_next = last_key;
    mode_next     = mode;
    add_amt       = 2'd0;
    app           = 1'b0;
    rep           = 1'b0;
    app_char      = t0;
    if (key_snap[1] && key_snap[2]) begin
      count_next    = '0;
      last_key_next = mte_pkg::NO_KEY;
      add_amt       = 2'd2;
    end else if (key_snap[4] && key_snap[5]) begin
      mode_next = !mode;
      add_amt   = 2'd2;
    end else if (key_snap[7] && key_snap[8]) begin
      if (last_key == mte_pkg::NO_KEY) begin
        app      = 1'b1;
        app_char = mte_pkg::CHAR_SPACE;
      end else begin
        last_key_next = mte_pkg::NO_KEY;
      end
      add_amt = 2'd2;
    end else if (key_snap != '0) begin
      if (mode) begin
        app      = 1'b1;
        app_char = mte_pkg::CHAR_ONE + 7'(k);
      end else if (last_key == k && count != '0) begin
        rep = 1'b1;
      end else begin
        app           = 1'b1;
        app_char      = t0;
        last_key_next = k;
      end
      add_amt = 2'd1;
    end
    if (app) begin
      if (count == mte_pkg::CNT_W'(mte_pkg::LINE_LEN)) begin
        head_next = mte_pkg::wrap_pos(head, mte_pkg::CNT_W'(1));
      end else begin
        count_next = count + 1'b1;
      end
    end
  end

  assign we    = cmd.apply && (app || rep);
  assign waddr = rep ? last_addr : app_addr;
  assign wdata = rep ? rep_char : app_char;
  assign rd_en = cmd.lookup || (cmd.emit && sts.out_free);
  assign raddr = cmd.lookup ? last_addr : emit_addr;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rdata <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key_snap <= s_tdata[8:0];
    end
    if (cmd.emit && sts.out_free) begin
      out_idx   <= cmd.emit_idx;
      out_last  <= cmd.emit_last;
      out_blank <= mte_pkg::CNT_W'(cmd.emit_idx) >= count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= '0;
      count     <= '0;
      last_key  <= mte_pkg::NO_KEY;
      mode      <= 1'b0;
      press_bcd <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.apply) begin
        head      <= head_next;
        count     <= count_next;
        last_key  <= last_key_next;
        mode      <= mode_next;
        press_bcd <= bcd_add(press_bcd, add_amt);
      end
      if (sts.out_free) begin
        out_valid <= cmd.emit;
      end
    end
  end

  assign m_tvalid = out_valid;
  assign m_tlast  = out_last;
  assign m_tdata  = {5'd0, press_bcd[3:0], press_bcd[7:4], press_bcd[11:8], press_bcd[15:12],
                     mode, 6'(count), (out_blank ? 7'd0 : rdata), out_idx};

endmodule

@@ hdl/mte_ctrl.sv @@
// Controller: sequences latch, lookup, apply and the per-character emit scan.
// Depends on mte_pkg; commands mte_datapath.
module mte_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  mte_pkg::sts_t sts,
  output mte_pkg::cmd_t cmd
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_LOOKUP = 4'b0010,
    ST_APPLY  = 4'b0100,
    ST_EMIT   = 4'b1000
  } state_t;

  state_t     state, state_next;
  logic [4:0] emit_cnt, emit_cnt_next;
  logic       at_last;

  assign at_last = emit_cnt == 5'(mte_pkg::SHOW_LEN - 1);

  always_comb begin
    state_next    = state;
    emit_cnt_next = emit_cnt;
    cmd           = '0;
    cmd.emit_idx  = emit_cnt;
    cmd.emit_last = at_last;
    s_tready      = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        if (sts.out_empty) begin
          cmd.lookup = 1'b1;
          state_next = ST_APPLY;
        end
      end
      ST_APPLY: begin
        cmd.apply     = 1'b1;
        emit_cnt_next = '0;
        state_next    = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit      = 1'b1;
          emit_cnt_next = emit_cnt + 1'b1;
          if (at_last) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      emit_cnt <= '0;
    end else begin
      state    <= state_next;
      emit_cnt <= emit_cnt_next;
    end
  end

endmodule

@@ test/multitap_text_entry_core_tb.sv @@
// Testbench for multitap_text_entry_core: drives nine-key snapshots, predicts every character
// beat of the text line and checks each output beat against the prediction.
// Depends on mte_pkg and the core RTL.
module multitap_text_entry_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [8:0] KEYS_CLEAR  = 9'h006;
  localparam logic [8:0] KEYS_TOGGLE = 9'h030;
  localparam logic [8:0] KEYS_SPACE  = 9'h180;
  localparam int         COUNT_MOD   = 10000;
  localparam int         PHASE_ITEMS = 64;

  typedef struct packed {
    logic [4:0] idx;
    logic [6:0] code;
    logic       last;
    logic [5:0] len;
    logic       mode;
    logic [3:0] thousands;
    logic [3:0] hundreds;
    logic [3:0] tens;
    logic [3:0] ones;
  } char_beat_t;

  class keypad_line_model;
    logic [6:0]  line[mte_pkg::LINE_LEN];
    logic [5:0]  len;
    logic [3:0]  last_key;
    logic        mode;
    int unsigned total;
    string       key_letters[9];
    char_beat_t  chars_due[$];
    int          errors;
    int          checked;

    function new();
      foreach (line[i]) line[i] = '0;
      len         = '0;
      last_key    = mte_pkg::NO_KEY;
      mode        = 1'b0;
      total       = 0;
      errors      = 0;
      checked     = 0;
      key_letters = '{".QZ", "ABC", "DEF", "GHI", "JKL", "MNO", "PRS", "TUV", "WXY"};
    endfunction

    function logic [6:0] letter_code(int k, int j);
      return 7'(key_letters[k][j]);
    endfunction

    function void push_char(logic [6:0] c);
      if (len >= mte_pkg::LINE_LEN) begin
        for (int i = 0; i < mte_pkg::LINE_LEN - 1; i++) line[i] = line[i + 1];
        len = 6'(mte_pkg::LINE_LEN - 1);
      end
      line[len] = c;
      len = len + 1'b1;
    endfunction

    function void take_keys(logic [8:0] keys);
      int         k;
      int         j;
      int         add;
      char_beat_t b;
      add = 0;
      if ((keys & KEYS_CLEAR) == KEYS_CLEAR) begin
        foreach (line[i]) line[i] = '0;
        len      = '0;
        last_key = mte_pkg::NO_KEY;
        add      = 2;
      end else if ((keys & KEYS_TOGGLE) == KEYS_TOGGLE) begin
        mode = !mode;
        add  = 2;
      end else if ((keys & KEYS_SPACE) == KEYS_SPACE) begin
        if (last_key == mte_pkg::NO_KEY) push_char(mte_pkg::CHAR_SPACE);
        else last_key = mte_pkg::NO_KEY;
        add = 2;
      end else if (keys != '0) begin
        k = 0;
        while (!keys[k]) k++;
        if (mode) begin
          push_char(7'(mte_pkg::CHAR_ONE + k));
        end else if (last_key == k && len > 0) begin
          j = 0;
          while (j < 3 && line[len - 1] != letter_code(k, j)) j++;
          line[len - 1] = letter_code(k, (j + 1) % 3);
        end else begin
          push_char(letter_code(k, 0));
          last_key = 4'(k);
        end
        add = 1;
      end
      total = (total + add) % COUNT_MOD;
      for (int n = 0; n < mte_pkg::SHOW_LEN; n++) begin
        b.idx       = 5'(n);
        b.code      = line[n];
        b.last      = (n == mte_pkg::SHOW_LEN - 1);
        b.len       = len;
        b.mode      = mode;
        b.thousands = 4'((total / 1000) % 10);
        b.hundreds  = 4'((total / 100) % 10);
        b.tens      = 4'((total / 10) % 10);
        b.ones      = 4'(total % 10);
        chars_due.push_back(b);
      end
    endfunction

    function void cmp(string name, logic [15:0] exp, logic [15:0] act);
      if (act !== exp) begin
        $error("%s: expected %0d, got %0d", name, exp, act);
        errors++;
      end
    endfunction

    function void check_char(logic [39:0] d, logic l);
      char_beat_t e;
      if (chars_due.size() == 0) begin
        $error("unexpected character beat: tdata %h", d);
        errors++;
        return;
      end
      e = chars_due.pop_front();
      checked++;
      cmp("char_index", 16'(e.idx), 16'(d[4:0]));
      cmp("char_code", 16'(e.code), 16'(d[11:5]));
      cmp("last_char", 16'(e.last), 16'(l));
      cmp("text_length", 16'(e.len), 16'(d[17:12]));
      cmp("number_mode", 16'(e.mode), 16'(d[18]));
      cmp("count_thousands", 16'(e.thousands), 16'(d[22:19]));
      cmp("count_hundreds", 16'(e.hundreds), 16'(d[26:23]));
      cmp("count_tens", 16'(e.tens), 16'(d[30:27]));
      cmp("count_ones", 16'(e.ones), 16'(d[34:31]));
      cmp("tdata padding", '0, 16'(d[39:35]));
    endfunction
  endclass

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata  = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;
  logic        m_tlast;

  keypad_line_model line_model;
  int               idle_pct  = 0;
  int               stall_pct = 0;
  int               snapshots = 0;
  int               prev_key  = 0;

  multitap_text_entry_core i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always #6 clk = ~clk;

  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) line_model.check_char(m_tdata, m_tlast);
  end

  // call at a falling edge; returns at the falling edge after the beat is taken
  task automatic send_keys(input logic [8:0] keys);
    while ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {7'b0, keys};
    do @(posedge clk); while (!s_tready);
    line_model.take_keys(keys);
    snapshots++;
    @(negedge clk);
  endtask

  function automatic logic [8:0] random_keys();
    int         r;
    int         k;
    logic [8:0] keys;
    r = $urandom_range(99);
    if (r < 3) begin
      keys = 9'($urandom) | KEYS_CLEAR;
    end else if (r < 8) begin
      keys = (9'($urandom) & ~9'h002) | KEYS_TOGGLE;
    end else if (r < 18) begin
      keys = (9'($urandom) & ~9'h012) | KEYS_SPACE;
    end else if (r < 21) begin
      keys = '0;
    end else if (r < 28) begin
      keys = 9'($urandom);
    end else begin
      k = ($urandom_range(99) < 55) ? prev_key : $urandom_range(8);
      prev_key = k;
      keys = 9'(1 << k);
      if ($urandom_range(99) < 30) begin
        keys = keys | (9'($urandom) & (9'h1FF << (k + 1)) & ~9'h124);
      end
    end
    return keys;
  endfunction

  initial begin
    static logic [8:0] directed[] = '{9'h000, 9'h001, 9'h001, 9'h001, 9'h001, 9'h100, 9'h180,
                                      9'h100, 9'h1FF, 9'h180, 9'h008, 9'h030, 9'h020, 9'h100,
                                      9'h0A1, 9'h030, 9'h008, 9'h0A8, 9'h0F0, 9'h0F0, 9'h040,
                                      9'h080, 9'h010};
    line_model = new();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);
    foreach (directed[i]) send_keys(directed[i]);
    for (int phase = 0; phase < 4; phase++) begin
      idle_pct  = (phase == 1) ? 75 : (phase == 3) ? 20 : 0;
      stall_pct = (phase == 2) ? 75 : (phase == 3) ? 20 : 0;
      repeat (PHASE_ITEMS) send_keys(random_keys());
    end
    s_tvalid <= 1'b0;
    idle_pct  = 0;
    stall_pct = 0;
    while (line_model.chars_due.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    $display("Sent %0d key snapshots (commands, digits, multi-tap letters, full-line shifts)",
             snapshots);
    $display("Checked %0d character beats under four sender/receiver idling mixes",
             line_model.checked);
    if (line_model.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+hdl
hdl/mte_pkg.sv
hdl/mte_datapath.sv
hdl/mte_ctrl.sv
hdl/multitap_text_entry_core.sv
test/multitap_text_entry_core_tb.sv
